@@ hw/rtl/ncls_pkg.sv @@
// ----------------------------------------------------------------------------
// ncls_pkg
// Shared types and constants for the node continuation line select unit.
// ----------------------------------------------------------------------------
package ncls_pkg;

  localparam int LINE_W     = 16;
  localparam int TOL_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_WAY   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNATTACHED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW   = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_TAIL,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decide;
    logic scan_rd;
    logic result_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/node_continuation_line_select_unit.sv @@
// ----------------------------------------------------------------------------
// node_continuation_line_select_unit
// Picks the line that continues the arriving line through one node.
// ----------------------------------------------------------------------------
// Usage: a node is sent as a run of entry requests on the input channel
// (in_valid / in_stall), one entry per cycle, the last one marked by
// last_entry. The arriving line id is taken from the first entry of each run.
// Each run yields exactly one result request on the output channel
// (out_valid / out_stall) carrying next_line and status.
// When a candidate scan is needed, the entries are read back from the entry
// RAM one per cycle, through ST_SCAN_RD and ST_SCAN_TAIL, and the result is
// registered from ST_FINISH once the output register is free; trivial cases
// (overflow, fewer than two entries, two-way node, unattached line) go from
// the last entry straight to ST_FINISH. The next node's entries are taken
// as soon as the result sits in the output register.
// Reset (synchronous, active high) clears the entry count, flags and
// configuration; the entry RAM needs no clearing. While the receiver stalls,
// the result is held and a further finished result waits in the unit, which
// then stalls its input. Configuration is written through cfg_we, cfg_index
// and cfg_data, by the user only while the unit is idle (not enforced).
// ----------------------------------------------------------------------------
module node_continuation_line_select_unit #(
  parameter int MAX_DEGREE = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ncls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ncls_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ncls_pkg::LINE_W-1:0] arriving_line,
  input  logic signed [ncls_pkg::LINE_W-1:0] entry_line,
  input  logic [ANGLE_BITS-1:0]              entry_angle,
  input  logic                               last_entry,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ncls_pkg::LINE_W-1:0] next_line,
  output logic [ncls_pkg::STATUS_W-1:0]      status
);

  ncls_pkg::cmd_t cmd;
  ncls_pkg::sts_t sts;

  ncls_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_entry (last_entry),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  ncls_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .arriving_line (arriving_line),
    .entry_line    (entry_line),
    .entry_angle   (entry_angle),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .next_line     (next_line),
    .status        (status)
  );

endmodule

@@ hw/rtl/ncls_ram.sv @@
// ----------------------------------------------------------------------------
// ncls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ncls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ncls_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncls_ctrl
// Controller: accepts entries, sequences the candidate scan and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
module ncls_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last_entry,
  output logic          in_stall,
  input  ncls_pkg::sts_t sts,
  output ncls_pkg::cmd_t cmd
);

  ncls_pkg::state_t state;
  ncls_pkg::state_t state_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncls_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    accept     = 1'b0;
    case (state)
      ncls_pkg::ST_LOAD: begin
        in_stall   = 1'b0;
        accept     = in_valid;
        cmd.load   = accept;
        cmd.decide = accept && last_entry;
        if (cmd.decide) begin
          state_next = sts.need_scan ? ncls_pkg::ST_SCAN_RD : ncls_pkg::ST_FINISH;
        end
      end
      ncls_pkg::ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        if (sts.rd_last) begin
          state_next = ncls_pkg::ST_SCAN_TAIL;
        end
      end
      ncls_pkg::ST_SCAN_TAIL: begin
        // The read of the last entry is evaluated in this cycle.
        state_next = ncls_pkg::ST_FINISH;
      end
      ncls_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ncls_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = ncls_pkg::ST_LOAD;
      end
    endcase
  end

  a_last_leaves_load: assert property (@(posedge clk) disable iff (rst)
    (state == ncls_pkg::ST_LOAD && in_valid && last_entry) |=> state != ncls_pkg::ST_LOAD)
    else $error("last entry did not start selection");

  a_stall_outside_load: assert property (@(posedge clk) disable iff (rst)
    (state != ncls_pkg::ST_LOAD) |-> in_stall)
    else $error("request accepted while selection in progress");

  a_tail_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ncls_pkg::ST_SCAN_TAIL) |-> $past(state) == ncls_pkg::ST_SCAN_RD)
    else $error("scan tail entered without a scan");

endmodule

@@ hw/rtl/ncls_datapath.sv @@
// ----------------------------------------------------------------------------
// ncls_datapath
// Entry store, arriving-line tracking, candidate scan and output register.
// ----------------------------------------------------------------------------
module ncls_datapath #(
  parameter int MAX_DEGREE = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ncls_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ncls_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [ncls_pkg::LINE_W-1:0]    arriving_line,
  input  logic signed [ncls_pkg::LINE_W-1:0]    entry_line,
  input  logic [ANGLE_BITS-1:0]                 entry_angle,
  input  ncls_pkg::cmd_t                        cmd,
  output ncls_pkg::sts_t                        sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ncls_pkg::LINE_W-1:0]    next_line,
  output logic [ncls_pkg::STATUS_W-1:0]         status
);

  localparam int IDX_W  = $clog2(MAX_DEGREE);
  localparam int CNT_W  = $clog2(MAX_DEGREE + 1);
  localparam int CMP_W  = (ANGLE_BITS > ncls_pkg::TOL_W) ? ANGLE_BITS : ncls_pkg::TOL_W;
  localparam int WORD_W = ncls_pkg::LINE_W + ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  // Configuration.
  logic [ncls_pkg::TOL_W-1:0] angle_tolerance;
  logic                       two_way_pass;

  // Per-node control state.
  logic [CNT_W-1:0]             entry_count;
  logic                         overflow_flag;
  logic                         found;
  logic signed [ncls_pkg::LINE_W-1:0] arriving_reg;
  logic [IDX_W-1:0]             scan_idx;
  logic                         rd_valid;
  logic                         have;

  // Payload.
  logic [ANGLE_BITS-1:0]        found_angle;
  logic [ANGLE_BITS-1:0]        target;
  logic [ANGLE_BITS-1:0]        best;
  logic signed [ncls_pkg::LINE_W-1:0] line0;
  logic signed [ncls_pkg::LINE_W-1:0] res_line;
  logic [ncls_pkg::STATUS_W-1:0] res_status;

  // Load-side decode.
  logic                         store_ok;
  logic [CNT_W-1:0]             cnt_after;
  logic                         ovf_after;
  logic signed [ncls_pkg::LINE_W-1:0] arr_eff;
  logic                         match_now;
  logic                         found_after;
  logic [ANGLE_BITS-1:0]        angle_after;
  logic                         few_entries;
  logic                         two_way_case;

  // Scan-side decode.
  logic [WORD_W-1:0]            rdata;
  logic signed [ncls_pkg::LINE_W-1:0] rd_line;
  logic [ANGLE_BITS-1:0]        rd_angle;
  logic [ANGLE_BITS-1:0]        diff;
  logic [ANGLE_BITS-1:0]        ang_dev;
  logic                         take;

  always_comb begin
    store_ok     = entry_count < CNT_W'(MAX_DEGREE);
    cnt_after    = store_ok ? entry_count + 1'b1 : entry_count;
    ovf_after    = overflow_flag || !store_ok;
    // The arriving line is taken from the first entry of a node.
    arr_eff      = (entry_count == '0) ? arriving_line : arriving_reg;
    match_now    = store_ok && !found && (entry_line == arr_eff);
    found_after  = found || match_now;
    angle_after  = match_now ? entry_angle : found_angle;
    few_entries  = cnt_after < CNT_W'(2);
    two_way_case = two_way_pass && (cnt_after == CNT_W'(2));
  end

  assign sts.need_scan = !ovf_after && !few_entries && !two_way_case && found_after;
  assign sts.rd_last   = (CNT_W'(scan_idx) + 1'b1) == entry_count;
  assign sts.out_free  = !out_valid || !out_stall;

  ncls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_DEGREE)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load && store_ok),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata ({entry_line, entry_angle}),
    .raddr (scan_idx),
    .rdata (rdata)
  );

  assign rd_line  = rdata[WORD_W-1:ANGLE_BITS];
  assign rd_angle = rdata[ANGLE_BITS-1:0];

  // Wrapped distance to the target direction, 0 .. half turn.
  always_comb begin
    diff    = rd_angle - target;
    ang_dev = (diff > HALF_TURN) ? (~diff + 1'b1) : diff;
    take    = rd_valid && (rd_line != arriving_reg)
        && (CMP_W'(ang_dev) <= CMP_W'(angle_tolerance))
        && (!have || ang_dev < best);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_tolerance <= '0;
      two_way_pass    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ncls_pkg::CFG_ANGLE_TOL: angle_tolerance <= cfg_data;
        ncls_pkg::CFG_TWO_WAY:   two_way_pass    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      overflow_flag <= 1'b0;
      found         <= 1'b0;
      arriving_reg  <= '0;
      scan_idx      <= '0;
      rd_valid      <= 1'b0;
      have          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd;
      if (cmd.load) begin
        if (entry_count == '0) begin
          arriving_reg <= arriving_line;
        end
        entry_count   <= cnt_after;
        overflow_flag <= ovf_after;
        found         <= found_after;
      end
      if (cmd.decide) begin
        scan_idx <= '0;
        have     <= 1'b0;
      end else if (cmd.scan_rd) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (take) begin
        have <= 1'b1;
      end
      if (cmd.result_load) begin
        entry_count   <= '0;
        overflow_flag <= 1'b0;
        found         <= 1'b0;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_angle <= angle_after;
      if (entry_count == '0) begin
        line0 <= entry_line;
      end
    end
    if (cmd.decide) begin
      target <= angle_after + HALF_TURN;
      if (ovf_after) begin
        res_line   <= '0;
        res_status <= ncls_pkg::STATUS_OVERFLOW;
      end else if (few_entries) begin
        res_line   <= '0;
        res_status <= ncls_pkg::STATUS_OK;
      end else if (two_way_case) begin
        // The second entry is the one arriving now.
        res_line   <= (line0 == arriving_reg) ? entry_line : line0;
        res_status <= ncls_pkg::STATUS_OK;
      end else if (!found_after) begin
        res_line   <= '0;
        res_status <= ncls_pkg::STATUS_UNATTACHED;
      end else begin
        res_line   <= '0;
        res_status <= ncls_pkg::STATUS_OK;
      end
    end
    if (take) begin
      best     <= ang_dev;
      res_line <= rd_line;
    end
    if (cmd.result_load) begin
      next_line <= res_line;
      status    <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_DEGREE))
    else $error("entry count beyond store depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> entry_count == CNT_W'(MAX_DEGREE))
    else $error("overflow flagged with room left");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> CNT_W'(scan_idx) < entry_count)
    else $error("scan read beyond loaded entries");

  a_result_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending output");

endmodule
